FILE: hdl/sksrch_pkg.sv
// Shared types and constants for the sorted-key binary search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sksrch_pkg;

   localparam int KEY_W     = 64;   // packed eight-character key
   localparam int POS_W     = 12;   // entry_index / position field width
   localparam int CNT_W     = 13;   // record_count width
   localparam int PROBE_W   = 4;    // probe counter width
   localparam int DEFAULT_TABLE_DEPTH = 4096;

   localparam logic [PROBE_W-1:0] PROBE_MAX = 4'd15;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 80;  // entry_index (12) + key_value (64) + pad
   localparam int RSP_DATA_W = 24;  // found (1) + position (12) + probes (4) + pad
   localparam int RSP_BITS   = 1 + POS_W + PROBE_W;

   // Operation codes carried on req_tuser
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP
   } state_type;

   // Result transaction; found lands in bit 0 when packed
   typedef struct packed {
      logic [PROBE_W-1:0] probes;
      logic [POS_W-1:0]   position;
      logic               found;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/sorted_key_binary_search.sv
// Top level of the sorted-key binary search block: stream ports, record count
// register, key table and search sequencer. Uses sksrch_pkg, sksrch_ram, sksrch_ctrl.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-----------------------------------------
//   req_    | in  | req_tvalid/req_tready | tdata: entry_index, key_value; tuser: op
//   rsp_    | out | rsp_tvalid/rsp_tready | tdata: found, position, probes
//   csr_    | in  | csr_valid/csr_ready   | csr_data: record_count
//
// Load transactions complete in the accept cycle and return nothing; req_tready stays high.
// A search runs a table read (ST_PROBE) then a compare (ST_CMP) for each probe,
// and an unsuccessful search closes in ST_PROBE once the window is empty.
// The key table RAM with its registered read is the probe loop bound.
// Reset (synchronous, active high) clears record_count and the sequencer; the
// table contents stay undefined until loaded. A stalled result holds the
// sequencer until the output register frees, while a finished result may
// still wait in the output register as the next request is taken.
`default_nettype none

module sorted_key_binary_search #(
   parameter int TABLE_DEPTH = sksrch_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [sksrch_pkg::REQ_DATA_W-1:0]  req_tdata,  // [11:0] entry_index, [75:12] key_value, [79:76] zero
   input  wire logic                               req_tuser,  // [0] operation
   // result stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [sksrch_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [0] found, [12:1] position, [16:13] probes, [23:17] zero
   // register write channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [sksrch_pkg::CNT_W-1:0]       csr_data    // record_count
);
   import sksrch_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [CNT_W-1:0] count_ff, count_in;

   logic [POS_W-1:0]   req_index;
   logic [KEY_W-1:0]   req_key;
   logic               req_xfer;
   logic               seq_idle;
   logic               search_start;
   logic               wr_en;
   logic [AW+POS_W-1:0] wr_wide;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [KEY_W-1:0]   rd_data;
   result_type         result;

   assign req_index = req_tdata[POS_W-1:0];
   assign req_key   = req_tdata[POS_W+KEY_W-1:POS_W];

   // one transaction at a time; loads complete in the accept cycle
   assign req_tready   = seq_idle;
   assign req_xfer     = req_tvalid && req_tready;
   assign search_start = req_xfer && (req_tuser == OP_SEARCH);

   // loads past the table end are dropped
   assign wr_en   = req_xfer && (req_tuser == OP_LOAD) && (32'(req_index) < TABLE_DEPTH);
   assign wr_wide = (AW+POS_W)'(req_index);
   assign wr_addr = wr_wide[AW-1:0];

   // record count register, always writable
   assign csr_ready = 1'b1;

   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   sksrch_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_key),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sksrch_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (search_start),
      .idle         (seq_idle),
      .key          (req_key),
      .record_count (count_ff),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_result   (result)
   );

   assign rsp_tdata = {(RSP_DATA_W-RSP_BITS)'(0), result};

endmodule

`default_nettype wire

FILE: hdl/sksrch_ram.sv
// Key table storage: one write port, one read port with registered data.
// Depends on sksrch_pkg for the key width.
`default_nettype none

module sksrch_ram #(
   parameter int DEPTH = sksrch_pkg::DEFAULT_TABLE_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire logic [sksrch_pkg::KEY_W-1:0]  wr_data,
   input  wire logic [AW-1:0]                 rd_addr,
   output logic      [sksrch_pkg::KEY_W-1:0]  rd_data
);
   import sksrch_pkg::*;

   logic [KEY_W-1:0] mem [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/sksrch_ctrl.sv
// Search sequencer: bounds registers, shared key comparator, probe counter
// and the result output register. Depends on sksrch_pkg.
`default_nettype none

module sksrch_ctrl #(
   parameter int TABLE_DEPTH = sksrch_pkg::DEFAULT_TABLE_DEPTH,
   parameter int AW          = $clog2(TABLE_DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request side
   input  wire logic                          start,      // search transaction accepted
   output logic                               idle,
   input  wire logic [sksrch_pkg::KEY_W-1:0]  key,
   input  wire logic [sksrch_pkg::CNT_W-1:0]  record_count,
   // table read port
   output logic      [AW-1:0]                 rd_addr,
   input  wire logic [sksrch_pkg::KEY_W-1:0]  rd_data,
   // result side
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output sksrch_pkg::result_type             rsp_result
);
   import sksrch_pkg::*;

   state_type state_ff, state_in;

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;      // first candidate
   logic [CNT_W-1:0]   hi1_ff, hi1_in;    // one past last candidate
   logic [PROBE_W-1:0] misses_ff, misses_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_result_ff, rsp_result_in;

   logic [CNT_W-1:0]    n_clamp;
   logic [CNT_W-1:0]    span;
   logic [CNT_W-1:0]    mid;
   logic [AW+CNT_W-1:0] mid_wide;
   logic                empty;
   logic                key_eq;
   logic                key_lt;
   logic                out_free;
   logic                emit;
   result_type          result;

   // record_count above the table depth searches the whole table
   always_comb begin
      if (32'(record_count) > TABLE_DEPTH) begin
         n_clamp = CNT_W'(TABLE_DEPTH);
      end else begin
         n_clamp = record_count;
      end
   end

   // shared compare unit
   assign empty    = (lo_ff >= hi1_ff);
   assign span     = hi1_ff - lo_ff - 1'b1;
   assign mid      = lo_ff + (span >> 1);
   assign mid_wide = (AW+CNT_W)'(mid);
   assign rd_addr  = mid_wide[AW-1:0];
   assign key_eq   = (key_ff == rd_data);
   assign key_lt   = (key_ff < rd_data);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!empty) begin
               state_in = ST_CMP;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (!key_eq) begin
               state_in = ST_PROBE;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      idle            = 1'b0;
      emit            = 1'b0;
      result.found    = 1'b0;
      result.position = '0;
      result.probes   = misses_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
         end
         ST_PROBE: begin
            emit = empty && out_free;
         end
         ST_CMP: begin
            emit            = key_eq && out_free;
            result.found    = 1'b1;
            result.position = mid[POS_W-1:0];
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   // bounds and probe count
   always_comb begin
      key_in    = key_ff;
      lo_in     = lo_ff;
      hi1_in    = hi1_ff;
      misses_in = misses_ff;
      if (start && state_ff == ST_IDLE) begin
         key_in    = key;
         lo_in     = '0;
         hi1_in    = n_clamp;
         misses_in = '0;
      end else if (state_ff == ST_CMP && !key_eq) begin
         if (key_lt) begin
            hi1_in = mid;
         end else begin
            lo_in = mid + 1'b1;
         end
         if (misses_ff != PROBE_MAX) begin
            misses_in = misses_ff + 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi1_ff        <= hi1_in;
      misses_ff     <= misses_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // a compare only follows a probe with a nonempty window
   a_cmp_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> lo_ff < hi1_ff)
      else $error("compare state with empty search window");

   // window never grows past the table depth
   a_hi_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> 32'(hi1_ff) <= TABLE_DEPTH)
      else $error("search window beyond table depth");

   // each mismatched probe adds one miss until saturation
   a_miss_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP && !key_eq && misses_ff != PROBE_MAX
      |=> misses_ff == $past(misses_ff) + 1'b1)
      else $error("probe count did not advance on a miss");

   // a miss result always reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_result_ff.found |-> rsp_result_ff.position == '0)
      else $error("not-found result with nonzero position");

endmodule

`default_nettype wire
